@@ design/ctc_greedy_decode_softmax_macros.svh @@
// ----------------------------------------------------------------------------
// CTC greedy decoder assertion macros
// Shared concurrent assertion forms, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef CTC_GREEDY_DECODE_SOFTMAX_MACROS_SVH
`define CTC_GREEDY_DECODE_SOFTMAX_MACROS_SVH

// Check a property outside of reset.
`define CTC_GDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check a property at every edge, reset included.
`define CTC_GDS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ design/ctc_gds_pkg.sv @@
// ----------------------------------------------------------------------------
// CTC greedy decoder package
// Constants, payload types and the exp table builder.
// ----------------------------------------------------------------------------
package ctc_gds_pkg;

    localparam int MAX_CLASSES     = 8192;
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int EXP_STEP_SHIFT  = 4;
    localparam logic [31:0] EXP_RATIO_Q32 = 32'd4034748382;

    localparam int LOGIT_W    = 16;
    localparam int CFG_W      = 14;
    localparam int KEY_W      = 13;
    localparam int CONF_W     = 16;
    localparam int EXP_W      = 17;
    localparam int SUM_W      = 32;
    localparam int DIVIDEND_W = SUM_W + 1;
    localparam int PROD_W     = SUM_W + EXP_W;
    localparam int FRAC_W     = 16;
    localparam int KIDX_W     = LOGIT_W - EXP_STEP_SHIFT;
    localparam int EXP_ADDR_W = $clog2(EXP_TABLE_DEPTH);
    localparam int COL_W      = $clog2(MAX_CLASSES);
    localparam int CMP_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit;
        logic                      end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key_index;
        logic [CONF_W-1:0] confidence;
        logic              has_char;
        logic              line_done;
    } out_item_t;

    typedef logic [EXP_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

    // T[k] = exp(-k/16) in Q1.16, from a Q1.32 running product.
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] p;
        p = 64'd1 << 32;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            rom[k] = EXP_W'((p + 64'd32768) >> 16);
            p = (p * {32'd0, EXP_RATIO_Q32} + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

endpackage

@@ design/ctc_gds_exp_rom.sv @@
// ----------------------------------------------------------------------------
// CTC greedy decoder exp table
// Constant exp(-k/16) table with a registered read port.
// ----------------------------------------------------------------------------
module ctc_gds_exp_rom (
    input  logic                               aclk,
    input  logic                               rd_en,
    input  logic [ctc_gds_pkg::EXP_ADDR_W-1:0] rd_addr,
    output logic [ctc_gds_pkg::EXP_W-1:0]      rd_data
);
    import ctc_gds_pkg::*;

    localparam exp_rom_t ROM = build_exp_rom();

    logic [EXP_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_reg <= ROM[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

@@ design/ctc_gds_divider.sv @@
// ----------------------------------------------------------------------------
// CTC greedy decoder divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctc_gds_divider (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [ctc_gds_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [ctc_gds_pkg::SUM_W-1:0]      divisor,
    output logic                               done,
    output logic [ctc_gds_pkg::DIVIDEND_W-1:0] quotient
);
    import ctc_gds_pkg::*;

    localparam int STEPS = DIVIDEND_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SUM_W-1:0]      rem_reg, rem_next;
    logic [SUM_W-1:0]      den_reg, den_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;

    logic [SUM_W:0] trial;
    logic [SUM_W:0] trial_diff;
    logic           fits;

    assign trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits       = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start) begin
            den_next  = (divisor == '0) ? SUM_W'(1) : divisor;
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/ctc_greedy_decode_softmax.sv @@
// ----------------------------------------------------------------------------
// CTC greedy decoder with online softmax confidence
// Per-row argmax, running softmax sum and CTC collapse of class scores.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one signed Q8.8 class score per transaction;
//   class_count transactions make one time step row. end_of_line is
//   sampled on the last score of a row. The m_ channel carries at most
//   one result per row: a decoded key with its Q0.16 confidence, and/or a
//   line-done marker on the last row of a text line.
//   The APB port holds class_count (0x0) and key_count (0x4); write them
//   only while the block is idle.
// Flow:
//   A score passes through LOOK after accept, and through SCALE as well
//   when it is a new row maximum (to rescale the sum after the multiply).
//   The exp table read is registered into LOOK, the sum multiply into SCALE.
//   A row that emits a key runs the 33-step restoring divider for 1/sum
//   before its result goes to OUT.
//   A line end without a key skips the divider and goes straight to OUT.
// Reset and stall:
//   Reset clears the row state, the previous index (blank) and the
//   result valid flag, and reloads both registers with 8192.
//   A stalled result holds in the output register; the next row's
//   scores are still taken, and only a further result waits for it.
// ----------------------------------------------------------------------------
module ctc_greedy_decode_softmax (
    input  logic                            aclk,
    input  logic                            aresetn,
    // score channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ctc_gds_pkg::in_item_t           s_data,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output ctc_gds_pkg::out_item_t          m_data,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ctc_gds_pkg::PADDR_W-1:0] paddr,
    input  logic [ctc_gds_pkg::PDATA_W-1:0] pwdata,
    output logic [ctc_gds_pkg::PDATA_W-1:0] prdata,
    output logic                            pready
);
    import ctc_gds_pkg::*;

    localparam logic REG_CLASS_COUNT = 1'b0;
    localparam logic REG_KEY_COUNT   = 1'b1;
    localparam int   REG_SEL_BIT     = 2;

    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(8192);
    localparam logic [SUM_W-1:0]  SUM_ONE   = SUM_W'(65536);
    localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
    localparam logic [CONF_W-1:0] CONF_MAX  = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCALE,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [CFG_W-1:0] cls_cnt_reg, cls_cnt_next;
    logic [CFG_W-1:0] key_cnt_reg, key_cnt_next;

    // row state
    logic [COL_W-1:0]          col_reg, col_next;
    logic signed [LOGIT_W-1:0] max_reg, max_next;
    logic [COL_W-1:0]          max_idx_reg, max_idx_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [COL_W-1:0]          prev_reg, prev_next;

    // captured score and its lookup flags
    logic signed [LOGIT_W-1:0] x_reg, x_next;
    logic                      eol_reg, eol_next;
    logic                      first_reg, first_next;
    logic                      gt_reg, gt_next;
    logic                      inr_reg, inr_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;

    // pending result
    logic [KEY_W-1:0]  pend_key_reg, pend_key_next;
    logic [CONF_W-1:0] pend_conf_reg, pend_conf_next;
    logic              pend_char_reg, pend_char_next;
    logic              pend_eol_reg, pend_eol_next;
    logic              div_start_reg, div_start_next;

    // result register
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    // datapath signals
    logic                   s_accept;
    logic                   gt_in;
    logic signed [LOGIT_W:0] diff_wide;
    logic [KIDX_W-1:0]      exp_k;
    logic                   inr_in;
    logic [EXP_ADDR_W-1:0]  rom_addr;
    logic [EXP_W-1:0]       rom_data;
    logic [EXP_W-1:0]       exp_val;
    logic [SUM_W:0]         add_sum;
    logic [PROD_W-1:0]      scale_rnd;
    logic [SUM_W+1:0]       scale_sum;
    logic [CMP_W-1:0]       row_len;
    logic                   row_end;
    logic                   fin;
    logic [COL_W-1:0]       idx_new;
    logic                   emit;
    logic [CMP_W-1:0]       key_tmp;
    logic                   cfg_wr;
    logic                   div_done;
    logic [DIVIDEND_W-1:0]  div_dividend;
    logic [DIVIDEND_W-1:0]  div_quot;

    assign s_ready  = aresetn && (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign pready   = 1'b1;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign cfg_wr   = psel && penable && pwrite;

    // distance from the running maximum selects the exp table entry
    assign gt_in     = s_data.logit > max_reg;
    assign diff_wide = gt_in ? ({s_data.logit[LOGIT_W-1], s_data.logit}
                                - {max_reg[LOGIT_W-1], max_reg})
                             : ({max_reg[LOGIT_W-1], max_reg}
                                - {s_data.logit[LOGIT_W-1], s_data.logit});
    assign exp_k     = diff_wide[LOGIT_W-1:EXP_STEP_SHIFT];
    assign inr_in    = {1'b0, exp_k} < (KIDX_W + 1)'(EXP_TABLE_DEPTH);
    assign rom_addr  = inr_in ? exp_k[EXP_ADDR_W-1:0] : '0;

    ctc_gds_exp_rom u_exp_rom (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    // confidence = round(2^32 / sum)
    assign div_dividend = {1'b1, SUM_W'(0)} + DIVIDEND_W'(sum_reg >> 1);

    ctc_gds_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign exp_val   = inr_reg ? rom_data : '0;
    assign add_sum   = {1'b0, sum_reg} + (SUM_W + 1)'(exp_val);
    assign scale_rnd = prod_reg + PROD_W'(32768);
    assign scale_sum = {1'b0, scale_rnd[PROD_W-1:FRAC_W]} + (SUM_W + 2)'(SUM_ONE);

    // clamp the row length into 1..MAX_CLASSES
    always_comb begin
        if (cls_cnt_reg == '0) begin
            row_len = CMP_W'(1);
        end else if (CMP_W'(cls_cnt_reg) > CMP_W'(MAX_CLASSES)) begin
            row_len = CMP_W'(MAX_CLASSES);
        end else begin
            row_len = CMP_W'(cls_cnt_reg);
        end
    end

    assign row_end = (CMP_W'(col_reg) + CMP_W'(1)) >= row_len;

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_CLASS_COUNT: prdata = PDATA_W'(cls_cnt_reg);
            REG_KEY_COUNT:   prdata = PDATA_W'(key_cnt_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        cls_cnt_next   = cls_cnt_reg;
        key_cnt_next   = key_cnt_reg;
        col_next       = col_reg;
        max_next       = max_reg;
        max_idx_next   = max_idx_reg;
        sum_next       = sum_reg;
        prev_next      = prev_reg;
        x_next         = x_reg;
        eol_next       = eol_reg;
        first_next     = first_reg;
        gt_next        = gt_reg;
        inr_next       = inr_reg;
        prod_next      = prod_reg;
        pend_key_next  = pend_key_reg;
        pend_conf_next = pend_conf_reg;
        pend_char_next = pend_char_reg;
        pend_eol_next  = pend_eol_reg;
        div_start_next = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        fin            = 1'b0;
        idx_new        = max_idx_reg;
        emit           = 1'b0;
        key_tmp        = '0;

        if (cfg_wr) begin
            case (paddr[REG_SEL_BIT])
                REG_CLASS_COUNT: cls_cnt_next = pwdata[CFG_W-1:0];
                REG_KEY_COUNT:   key_cnt_next = pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                // capture the score; the table read runs in parallel
                if (s_accept) begin
                    x_next     = s_data.logit;
                    eol_next   = s_data.end_of_line;
                    first_next = (col_reg == '0);
                    gt_next    = gt_in;
                    inr_next   = inr_in;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                if (first_reg) begin
                    sum_next   = SUM_ONE;
                    max_next   = x_reg;
                    idx_new    = '0;
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end else if (gt_reg) begin
                    prod_next  = PROD_W'(sum_reg) * PROD_W'(exp_val);
                    state_next = S_SCALE;
                end else begin
                    sum_next   = add_sum[SUM_W] ? SUM_MAX : add_sum[SUM_W-1:0];
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCALE: begin
                // rescale the sum to the new maximum
                sum_next   = (scale_sum[SUM_W+1:SUM_W] != 2'b00) ? SUM_MAX
                                                                 : scale_sum[SUM_W-1:0];
                max_next   = x_reg;
                idx_new    = col_reg;
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    pend_conf_next = (div_quot > DIVIDEND_W'(CONF_MAX)) ? CONF_MAX
                                                                       : div_quot[CONF_W-1:0];
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.key_index  = pend_key_reg;
                    m_data_next.confidence = pend_conf_reg;
                    m_data_next.has_char   = pend_char_reg;
                    m_data_next.line_done  = pend_eol_reg;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // close out the score: advance the column or finish the row
        if (fin) begin
            max_idx_next = idx_new;
            emit         = (idx_new != '0) && (CMP_W'(idx_new) < CMP_W'(key_cnt_reg))
                           && (idx_new != prev_reg);
            key_tmp      = CMP_W'(idx_new) - CMP_W'(1);
            if (!row_end) begin
                col_next = col_reg + COL_W'(1);
            end else begin
                col_next  = '0;
                prev_next = eol_reg ? '0 : idx_new;
                if (emit) begin
                    pend_key_next  = key_tmp[KEY_W-1:0];
                    pend_char_next = 1'b1;
                    pend_eol_next  = eol_reg;
                    div_start_next = 1'b1;
                    state_next     = S_DIV;
                end else if (eol_reg) begin
                    pend_key_next  = '0;
                    pend_conf_next = '0;
                    pend_char_next = 1'b0;
                    pend_eol_next  = 1'b1;
                    state_next     = S_OUT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cls_cnt_reg   <= CFG_RESET;
            key_cnt_reg   <= CFG_RESET;
            col_reg       <= '0;
            max_reg       <= '0;
            max_idx_reg   <= '0;
            sum_reg       <= '0;
            prev_reg      <= '0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cls_cnt_reg   <= cls_cnt_next;
            key_cnt_reg   <= key_cnt_next;
            col_reg       <= col_next;
            max_reg       <= max_next;
            max_idx_reg   <= max_idx_next;
            sum_reg       <= sum_next;
            prev_reg      <= prev_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
        end
        x_reg         <= x_next;
        eol_reg       <= eol_next;
        first_reg     <= first_next;
        gt_reg        <= gt_next;
        inr_reg       <= inr_next;
        prod_reg      <= prod_next;
        pend_key_reg  <= pend_key_next;
        pend_conf_reg <= pend_conf_next;
        pend_char_reg <= pend_char_next;
        pend_eol_reg  <= pend_eol_next;
        m_data_reg    <= m_data_next;
    end

endmodule

@@ design/ctc_gds_checker.sv @@
// ----------------------------------------------------------------------------
// CTC greedy decoder port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "ctc_greedy_decode_softmax_macros.svh"

module ctc_gds_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input ctc_gds_pkg::out_item_t m_data,
    input logic                   pready
);
    import ctc_gds_pkg::*;

    // accepting a score takes the block out of idle, so s_ready drops
    `CTC_GDS_ASSERT(a_busy_after_accept, (s_valid && s_ready) |=> !s_ready, "ready after accept")

    // stalled result holds
    `CTC_GDS_ASSERT(a_result_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)), "result changed while stalled")

    // a result without a key is a line end with cleared payload
    `CTC_GDS_ASSERT(a_empty_result, (m_valid && !m_data.has_char) |-> (m_data.line_done && (m_data.key_index == '0) && (m_data.confidence == '0)), "bad empty result")

    // configuration port never waits
    `CTC_GDS_ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule

bind ctc_greedy_decode_softmax ctc_gds_checker u_ctc_gds_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);
